FILE: design/hrl_pkg.sv
// Shared types, constants and control codes of the hex record loader.
package hrl_pkg;

   localparam int MAX_DATA_BYTES_DEF = 32;

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_SEVEN = 8'h37;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_NUL = 8'h00;

   localparam logic [7:0] REC_DATA = 8'h00;
   localparam logic [7:0] REC_EOF = 8'h01;
   localparam logic [7:0] REC_LAST_KNOWN = 8'h05;
   localparam logic [7:0] REC_FIRST_KNOWN = 8'h02;

   localparam logic [14:0] CONFIG_BASE = 15'h2000;
   localparam logic [8:0] POS_MAX = 9'd511;
   localparam logic [8:0] HEADER_PLUS_SUM = 9'd5;

   typedef enum logic [2:0] {
      STS_LINE_OK = 3'd0,
      STS_DONE = 3'd1,
      STS_NO_COLON = 3'd2,
      STS_BAD_COUNT = 3'd3,
      STS_BAD_SUM = 3'd4,
      STS_UNSUPPORTED = 3'd5,
      STS_UNKNOWN = 3'd6,
      STS_TOO_LONG = 3'd7
   } status_code_type;

   typedef enum logic [3:0] {
      ST_RUN,
      ST_CHECK,
      ST_RD_LO,
      ST_RD_HI,
      ST_RD_WAIT,
      ST_WORD,
      ST_OK,
      ST_FINAL,
      ST_EOS,
      ST_HALT
   } state_type;

   typedef struct packed {
      logic take_char;
      logic init_words;
      logic rd_step;
      logic latch_lo;
      logic latch_hi;
      logic load_word;
      logic load_status;
      status_code_type status;
      logic last;
      logic clear_line;
   } ctrl_cmd_type;

   typedef struct packed {
      logic line_active;
      logic data_ok;
      status_code_type fail_code;
      logic len_zero;
      logic rem_le2;
      logic out_free;
   } dp_stat_type;

endpackage

FILE: design/hrl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hrl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 37
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

FILE: design/hrl_ctrl.sv
// Controller state machine: character intake, line end checks and result sequencing.
module hrl_ctrl
   import hrl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [7:0]   req_char_in,
   input  logic         req_stream_end,
   input  dp_stat_type  dp_stat,
   output ctrl_cmd_type cmd
);

   state_type state_ff, state_in;
   logic eos_ff, eos_in;
   logic accept;

   assign accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         eos_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         eos_ff <= eos_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      eos_in = eos_ff;
      case (state_ff)
         ST_RUN: begin
            if (accept) begin
               if (req_stream_end) begin
                  eos_in = 1'b1;
                  state_in = dp_stat.line_active ? ST_CHECK : ST_EOS;
               end else if (req_char_in == CHAR_LF) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (dp_stat.data_ok) begin
               state_in = dp_stat.len_zero ? ST_OK : ST_RD_LO;
            end else begin
               state_in = ST_FINAL;
            end
         end
         ST_RD_LO: state_in = ST_RD_HI;
         ST_RD_HI: state_in = ST_RD_WAIT;
         ST_RD_WAIT: state_in = ST_WORD;
         ST_WORD: begin
            if (dp_stat.out_free) begin
               state_in = dp_stat.rem_le2 ? ST_OK : ST_RD_LO;
            end
         end
         ST_OK: begin
            if (dp_stat.out_free) begin
               state_in = eos_ff ? ST_EOS : ST_RUN;
            end
         end
         ST_FINAL: begin
            if (dp_stat.out_free) begin
               state_in = ST_HALT;
            end
         end
         ST_EOS: begin
            if (dp_stat.out_free) begin
               state_in = ST_HALT;
            end
         end
         ST_HALT: state_in = ST_HALT;
         default: state_in = ST_HALT;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      cmd = '0;
      cmd.status = STS_LINE_OK;
      case (state_ff)
         ST_RUN: begin
            req_stall = 1'b0;
            cmd.take_char = req_valid && !req_stream_end && (req_char_in != CHAR_LF);
         end
         ST_CHECK: cmd.init_words = dp_stat.data_ok;
         ST_RD_LO: cmd.rd_step = 1'b1;
         ST_RD_HI: begin
            cmd.latch_lo = 1'b1;
            cmd.rd_step = 1'b1;
         end
         ST_RD_WAIT: cmd.latch_hi = 1'b1;
         ST_WORD: cmd.load_word = dp_stat.out_free;
         ST_OK: begin
            cmd.load_status = dp_stat.out_free;
            cmd.status = STS_LINE_OK;
            cmd.last = !eos_ff;
            cmd.clear_line = dp_stat.out_free;
         end
         ST_FINAL: begin
            cmd.load_status = dp_stat.out_free;
            cmd.status = dp_stat.fail_code;
            cmd.last = 1'b1;
            cmd.clear_line = dp_stat.out_free;
         end
         ST_EOS: begin
            cmd.load_status = dp_stat.out_free;
            cmd.status = STS_TOO_LONG;
            cmd.last = 1'b1;
         end
         ST_HALT: req_stall = 1'b0;
         default: req_stall = 1'b0;
      endcase
   end

`ifndef NO_ASSERTIONS
   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_HALT |-> !cmd.load_word && !cmd.load_status)
      else $error("result produced after the block halted");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_word || cmd.load_status) |-> dp_stat.out_free)
      else $error("result loaded while the output register is occupied");

   a_eos_sticky: assert property (@(posedge clock) disable iff (reset)
      eos_ff |=> eos_ff)
      else $error("stream end flag cleared");

   a_no_intake_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.take_char |-> state_ff == ST_RUN)
      else $error("character taken outside the intake state");
`endif

endmodule

FILE: design/hrl_dp.sv
// Datapath: digit decoding, line byte store, running checksum and result register.
module hrl_dp
   import hrl_pkg::*;
#(
   parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic [7:0]   req_char_in,
   input  ctrl_cmd_type cmd,
   output dp_stat_type  dp_stat,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic         rsp_item_kind,
   output logic         rsp_target_store,
   output logic [15:0]  rsp_word_address,
   output logic [15:0]  rsp_word_value,
   output logic [2:0]   rsp_status_code,
   output logic         rsp_last_of_run
);

   localparam int LINE_DEPTH = MAX_DATA_BYTES + 5;
   localparam int CNT_W = $clog2(LINE_DEPTH + 1);
   localparam int ADDR_W = $clog2(LINE_DEPTH);

   logic colon_ff, colon_in;
   logic stopped_ff, stopped_in;
   logic ovf_ff, ovf_in;
   logic pending_ff, pending_in;
   logic [8:0] pos_ff, pos_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [3:0] hi_nib_ff, hi_nib_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] ahi_ff, ahi_in;
   logic [7:0] alo_ff, alo_in;
   logic [7:0] type_ff, type_in;
   logic [7:0] rem_ff, rem_in;
   logic [ADDR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [7:0] lo_ff, lo_in;
   logic [7:0] hi_ff, hi_in;
   logic [15:0] waddr_ff, waddr_in;
   logic store_ff, store_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic kind_ff, kind_in;
   logic tstore_ff, tstore_in;
   logic [15:0] oaddr_ff, oaddr_in;
   logic [15:0] oval_ff, oval_in;
   logic [2:0] code_ff, code_in;
   logic olast_ff, olast_in;

   logic [7:0] nib;
   logic [7:0] byte_val;
   logic wr_en;
   logic [7:0] rd_data;
   logic [14:0] base;
   logic count_ok;

   assign nib = (req_char_in <= CHAR_NINE) ? (req_char_in - CHAR_ZERO)
                                            : (req_char_in - CHAR_SEVEN);
   assign byte_val = {hi_nib_ff, 4'h0} + nib;
   assign base = {ahi_ff, alo_ff[7:1]};
   assign count_ok = (cnt_ff != '0) && (9'(cnt_ff) == (9'(len_ff) + HEADER_PLUS_SUM));

   hrl_ram #(
      .WIDTH(8),
      .DEPTH(LINE_DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[ADDR_W-1:0]),
      .wr_data (byte_val),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      dp_stat.line_active = (pos_ff != '0);
      dp_stat.len_zero = (len_ff == 8'h00);
      dp_stat.rem_le2 = (rem_ff <= 8'd2);
      dp_stat.out_free = !rsp_valid_ff || !rsp_stall;
      dp_stat.data_ok = 1'b0;
      if (!colon_ff) begin
         dp_stat.fail_code = STS_NO_COLON;
      end else if (ovf_ff) begin
         dp_stat.fail_code = STS_TOO_LONG;
      end else if (!count_ok) begin
         dp_stat.fail_code = STS_BAD_COUNT;
      end else if (sum_ff != 8'h00) begin
         dp_stat.fail_code = STS_BAD_SUM;
      end else if (type_ff == REC_DATA) begin
         dp_stat.fail_code = STS_LINE_OK;
         dp_stat.data_ok = 1'b1;
      end else if (type_ff == REC_EOF) begin
         dp_stat.fail_code = STS_DONE;
      end else if (type_ff >= REC_FIRST_KNOWN && type_ff <= REC_LAST_KNOWN) begin
         dp_stat.fail_code = STS_UNSUPPORTED;
      end else begin
         dp_stat.fail_code = STS_UNKNOWN;
      end
   end

   always_comb begin
      colon_in = colon_ff;
      stopped_in = stopped_ff;
      ovf_in = ovf_ff;
      pending_in = pending_ff;
      pos_in = pos_ff;
      cnt_in = cnt_ff;
      hi_nib_in = hi_nib_ff;
      sum_in = sum_ff;
      len_in = len_ff;
      ahi_in = ahi_ff;
      alo_in = alo_ff;
      type_in = type_ff;
      wr_en = 1'b0;
      if (cmd.clear_line) begin
         colon_in = 1'b0;
         stopped_in = 1'b0;
         ovf_in = 1'b0;
         pending_in = 1'b0;
         pos_in = '0;
         cnt_in = '0;
         sum_in = 8'h00;
      end else if (cmd.take_char) begin
         if (pos_ff == '0) begin
            colon_in = (req_char_in == CHAR_COLON);
            pos_in = 9'd1;
         end else begin
            if (pos_ff != POS_MAX) begin
               pos_in = pos_ff + 9'd1;
            end
            if (!stopped_ff) begin
               if (req_char_in == CHAR_CR || req_char_in == CHAR_NUL) begin
                  stopped_in = 1'b1;
               end else if (!ovf_ff) begin
                  if (!pending_ff) begin
                     if (cnt_ff >= CNT_W'(LINE_DEPTH)) begin
                        ovf_in = 1'b1;
                     end else begin
                        hi_nib_in = nib[3:0];
                        pending_in = 1'b1;
                     end
                  end else begin
                     wr_en = 1'b1;
                     sum_in = sum_ff + byte_val;
                     cnt_in = cnt_ff + CNT_W'(1);
                     pending_in = 1'b0;
                     if (cnt_ff == CNT_W'(0)) begin
                        len_in = byte_val;
                     end
                     if (cnt_ff == CNT_W'(1)) begin
                        ahi_in = byte_val;
                     end
                     if (cnt_ff == CNT_W'(2)) begin
                        alo_in = byte_val;
                     end
                     if (cnt_ff == CNT_W'(3)) begin
                        type_in = byte_val;
                     end
                  end
               end
            end
         end
      end
   end

   always_comb begin
      rem_in = rem_ff;
      rd_ptr_in = rd_ptr_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      waddr_in = waddr_ff;
      store_in = store_ff;
      if (cmd.init_words) begin
         rem_in = len_ff;
         rd_ptr_in = ADDR_W'(4);
         store_in = (base >= CONFIG_BASE);
         waddr_in = (base >= CONFIG_BASE) ? ({1'b0, base} - {1'b0, CONFIG_BASE})
                                          : {1'b0, base};
      end
      if (cmd.rd_step) begin
         rd_ptr_in = rd_ptr_ff + ADDR_W'(1);
      end
      if (cmd.latch_lo) begin
         lo_in = rd_data;
      end
      if (cmd.latch_hi) begin
         hi_in = (rem_ff >= 8'd2) ? rd_data : 8'h00;
      end
      if (cmd.load_word) begin
         waddr_in = waddr_ff + 16'd1;
         rem_in = (rem_ff <= 8'd2) ? 8'h00 : (rem_ff - 8'd2);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kind_in = kind_ff;
      tstore_in = tstore_ff;
      oaddr_in = oaddr_ff;
      oval_in = oval_ff;
      code_in = code_ff;
      olast_in = olast_ff;
      if (cmd.load_word) begin
         rsp_valid_in = 1'b1;
         kind_in = 1'b0;
         tstore_in = store_ff;
         oaddr_in = waddr_ff;
         oval_in = {hi_ff, lo_ff};
         code_in = STS_LINE_OK;
         olast_in = 1'b0;
      end else if (cmd.load_status) begin
         rsp_valid_in = 1'b1;
         kind_in = 1'b1;
         tstore_in = 1'b0;
         oaddr_in = 16'h0000;
         oval_in = 16'h0000;
         code_in = cmd.status;
         olast_in = cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         colon_ff <= 1'b0;
         stopped_ff <= 1'b0;
         ovf_ff <= 1'b0;
         pending_ff <= 1'b0;
         pos_ff <= '0;
         cnt_ff <= '0;
         sum_ff <= 8'h00;
         rsp_valid_ff <= 1'b0;
      end else begin
         colon_ff <= colon_in;
         stopped_ff <= stopped_in;
         ovf_ff <= ovf_in;
         pending_ff <= pending_in;
         pos_ff <= pos_in;
         cnt_ff <= cnt_in;
         sum_ff <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hi_nib_ff <= hi_nib_in;
      len_ff <= len_in;
      ahi_ff <= ahi_in;
      alo_ff <= alo_in;
      type_ff <= type_in;
      rem_ff <= rem_in;
      rd_ptr_ff <= rd_ptr_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      waddr_ff <= waddr_in;
      store_ff <= store_in;
      kind_ff <= kind_in;
      tstore_ff <= tstore_in;
      oaddr_ff <= oaddr_in;
      oval_ff <= oval_in;
      code_ff <= code_in;
      olast_ff <= olast_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item_kind = kind_ff;
   assign rsp_target_store = tstore_ff;
   assign rsp_word_address = oaddr_ff;
   assign rsp_word_value = oval_ff;
   assign rsp_status_code = code_ff;
   assign rsp_last_of_run = olast_ff;

endmodule

FILE: design/hex_record_loader_unit.sv
// Top level of the hex record loader: controller and datapath.
//
//   Channel  Direction  Handshake          Payload
//   req      in         req_valid/stall    char_in, stream_end
//   rsp      out        rsp_valid/stall    item_kind, target_store, word_address,
//                                          word_value, status_code, last_of_run
//
// An ordinary character is taken in the intake state, and the next one can follow at
// once. A line feed passes a check state and a status state; a data record adds the
// states RD_LO, RD_HI, RD_WAIT and WORD per word, set by two registered RAM reads.
// Reset clears line flags, counters, checksum and output valid; the line RAM is not
// cleared. A stall on rsp holds the result in the output register and pauses the
// sequence. After a final status the block keeps taking items and produces nothing.
module hex_record_loader_unit
   import hrl_pkg::*;
#(
   parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_in,
   input  logic        req_stream_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_item_kind,
   output logic        rsp_target_store,
   output logic [15:0] rsp_word_address,
   output logic [15:0] rsp_word_value,
   output logic [2:0]  rsp_status_code,
   output logic        rsp_last_of_run
);

   ctrl_cmd_type cmd;
   dp_stat_type dp_stat;

   hrl_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_char_in    (req_char_in),
      .req_stream_end (req_stream_end),
      .dp_stat        (dp_stat),
      .cmd            (cmd)
   );

   hrl_dp #(
      .MAX_DATA_BYTES(MAX_DATA_BYTES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_char_in      (req_char_in),
      .cmd              (cmd),
      .dp_stat          (dp_stat),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_item_kind    (rsp_item_kind),
      .rsp_target_store (rsp_target_store),
      .rsp_word_address (rsp_word_address),
      .rsp_word_value   (rsp_word_value),
      .rsp_status_code  (rsp_status_code),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule
